// ----- sv/hrl_pkg.sv -----
package hrl_pkg;

    localparam int IMG_AW   = 16;
    localparam int ROW_AW   = 8;
    localparam int LINE_AW  = 8;
    localparam int ROW_CNT  = 1 << ROW_AW;

    localparam logic [LINE_AW-1:0] LINE_LAST = 8'd255;
    localparam logic [LINE_AW-1:0] MIN_LINE  = 8'd11;
    localparam logic [7:0] COLON     = 8'h3a;
    localparam logic [7:0] NEWLINE   = 8'h0a;
    localparam logic [7:0] CASE_MASK = 8'hdf;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_EOF  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LINE = 2'd0,
        KIND_FILE = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NO_END = 3'd1,
        ST_SHORT  = 3'd2,
        ST_COLON  = 3'd3,
        ST_HEX    = 3'd4,
        ST_TYPE   = 3'd5,
        ST_CSUM   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD,
        S_USE,
        S_FIN,
        S_RDIMG,
        S_OUT
    } state_t;

    // bit 4 flags a character that is not a hex digit
    function automatic logic [4:0] nibble(input logic [7:0] c);
        logic [7:0] u;
        u = c & CASE_MASK;
        if (c >= 8'h30 && c <= 8'h39) begin
            nibble = {1'b0, 4'(c - 8'h30)};
        end else if (u >= 8'h41 && u <= 8'h46) begin
            nibble = {1'b0, 4'(u - 8'h37)};
        end else begin
            nibble = 5'h10;
        end
    endfunction

endpackage

// ----- sv/hex_record_loader_unit.sv -----
// channel  | handshake         | payload
// s_ (in)  | s_valid / s_ready | s_op, s_ch, s_read_address
// m_ (out) | m_valid / m_ready | m_kind, m_status, m_read_data, m_row_tag
//
// A character that does not end a line is written to the line buffer and the unit
// stays idle. At a newline, or a full 255-character chunk, the sequencer walks the
// line buffer one character at a time (buffer read, then decode).
// A read goes through the registered image port, then S_RDIMG and S_OUT.
// After reset the image is zeroed one byte a cycle, with s_ready low.
// A result waits in the output register; s_ready is high only while idle, so it stays
// low while an item is processed and while a result is pending behind it.
module hex_record_loader_unit
    import hrl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [7:0]          s_ch,
    input  logic [IMG_AW-1:0]   s_read_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [2:0]          m_status,
    output logic [7:0]          m_read_data,
    output logic                m_row_tag
);

    state_t               state_reg, state_next;
    logic [LINE_AW-1:0]   count_reg, count_next;
    logic                 zseen_reg, zseen_next;
    logic [LINE_AW-1:0]   zpos_reg, zpos_next;
    logic [LINE_AW-1:0]   len_reg, len_next;
    logic [LINE_AW-1:0]   pos_reg, pos_next;
    logic [3:0]           hi_reg, hi_next;
    logic [7:0]           n_reg, n_next;
    logic [7:0]           ah_reg, ah_next;
    logic [IMG_AW-1:0]    waddr_reg, waddr_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           left_reg, left_next;
    status_t              stat_reg, stat_next;
    status_t              held_reg, held_next;
    logic                 endseen_reg, endseen_next;
    logic                 eof_reg, eof_next;
    logic [IMG_AW-1:0]    clr_reg, clr_next;
    logic [ROW_AW-1:0]    rrow_reg, rrow_next;
    logic [ROW_CNT-1:0]   tags_reg, tags_next;
    kind_t                res_kind_reg, res_kind_next;
    status_t              res_stat_reg, res_stat_next;
    logic [7:0]           res_data_reg, res_data_next;
    logic                 res_tag_reg, res_tag_next;
    logic                 m_valid_reg, m_valid_next;
    kind_t                m_kind_reg, m_kind_next;
    status_t              m_stat_reg, m_stat_next;
    logic [7:0]           m_data_reg, m_data_next;
    logic                 m_tag_reg, m_tag_next;

    logic [7:0]           line_buf [0:(1 << LINE_AW)-1];
    logic [7:0]           buf_q_reg;
    logic                 buf_we, buf_re;

    logic [7:0]           image [0:(1 << IMG_AW)-1];
    logic [7:0]           img_q_reg;
    logic                 img_we, img_re;
    logic [IMG_AW-1:0]    img_wa;
    logic [7:0]           img_wd;

    logic                 accept;
    logic [4:0]           nib;
    logic [7:0]           byte_w;
    logic [LINE_AW-1:0]   len_w;
    logic [LINE_AW+1:0]   need_w;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign nib      = nibble(buf_q_reg);
    assign byte_w   = {hi_reg, nib[3:0]};
    assign len_w    = zseen_reg ? zpos_reg : count_reg;
    assign need_w   = {2'b00, MIN_LINE} + {1'b0, n_reg, 1'b0};
    assign buf_re   = (state_reg == S_RD);
    assign img_re   = accept && (op_t'(s_op) == OP_READ);

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_status    = m_stat_reg;
    assign m_read_data = m_data_reg;
    assign m_row_tag   = m_tag_reg;

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            line_buf[count_reg] <= s_ch;
        end
        if (buf_re) begin
            buf_q_reg <= line_buf[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (img_we) begin
            image[img_wa] <= img_wd;
        end
        if (img_re) begin
            img_q_reg <= image[s_read_address];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            zseen_reg   <= 1'b0;
            held_reg    <= ST_OK;
            endseen_reg <= 1'b0;
            eof_reg     <= 1'b0;
            clr_reg     <= '0;
            tags_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            zseen_reg   <= zseen_next;
            held_reg    <= held_next;
            endseen_reg <= endseen_next;
            eof_reg     <= eof_next;
            clr_reg     <= clr_next;
            tags_reg    <= tags_next;
            m_valid_reg <= m_valid_next;
        end
        zpos_reg     <= zpos_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        hi_reg       <= hi_next;
        n_reg        <= n_next;
        ah_reg       <= ah_next;
        waddr_reg    <= waddr_next;
        sum_reg      <= sum_next;
        left_reg     <= left_next;
        stat_reg     <= stat_next;
        rrow_reg     <= rrow_next;
        res_kind_reg <= res_kind_next;
        res_stat_reg <= res_stat_next;
        res_data_reg <= res_data_next;
        res_tag_reg  <= res_tag_next;
        m_kind_reg   <= m_kind_next;
        m_stat_reg   <= m_stat_next;
        m_data_reg   <= m_data_next;
        m_tag_reg    <= m_tag_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        zseen_next    = zseen_reg;
        zpos_next     = zpos_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        hi_next       = hi_reg;
        n_next        = n_reg;
        ah_next       = ah_reg;
        waddr_next    = waddr_reg;
        sum_next      = sum_reg;
        left_next     = left_reg;
        stat_next     = stat_reg;
        held_next     = held_reg;
        endseen_next  = endseen_reg;
        eof_next      = eof_reg;
        clr_next      = clr_reg;
        rrow_next     = rrow_reg;
        tags_next     = tags_reg;
        res_kind_next = res_kind_reg;
        res_stat_next = res_stat_reg;
        res_data_next = res_data_reg;
        res_tag_next  = res_tag_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_stat_next   = m_stat_reg;
        m_data_next   = m_data_reg;
        m_tag_next    = m_tag_reg;
        buf_we        = 1'b0;
        img_we        = 1'b0;
        img_wa        = waddr_reg;
        img_wd        = byte_w;

        case (state_reg)
            S_CLEAR: begin
                img_we   = 1'b1;
                img_wa   = clr_reg;
                img_wd   = 8'h00;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {IMG_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (op_t'(s_op))
                        OP_CHAR: begin
                            buf_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (s_ch == CHAR_NUL && !zseen_reg) begin
                                zseen_next = 1'b1;
                                zpos_next  = count_reg;
                            end
                            if (s_ch == NEWLINE || count_next == LINE_LAST) begin
                                eof_next   = 1'b0;
                                state_next = S_START;
                            end
                        end
                        OP_EOF: begin
                            eof_next = 1'b1;
                            if (count_reg != '0) begin
                                state_next = S_START;
                            end else begin
                                stat_next  = held_reg;
                                state_next = S_FIN;
                            end
                        end
                        OP_READ: begin
                            rrow_next  = s_read_address[IMG_AW-1 -: ROW_AW];
                            state_next = S_RDIMG;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_START: begin
                len_next = len_w;
                pos_next = '0;
                sum_next = '0;
                // a held error skips the line
                if (held_reg != ST_OK) begin
                    stat_next  = held_reg;
                    state_next = S_FIN;
                end else if (len_w < MIN_LINE) begin
                    stat_next  = ST_SHORT;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_USE;
            end
            S_USE: begin
                pos_next   = pos_reg + 1'b1;
                state_next = S_RD;
                if (pos_reg == '0) begin
                    if (buf_q_reg != COLON) begin
                        stat_next  = ST_COLON;
                        state_next = S_FIN;
                    end
                end else if (nib[4]) begin
                    stat_next  = ST_HEX;
                    state_next = S_FIN;
                end else if (pos_reg[0]) begin
                    hi_next = nib[3:0];
                end else if (pos_reg <= 8'd8) begin
                    sum_next = sum_reg + byte_w;
                    case (pos_reg)
                        8'd2: n_next  = byte_w;
                        8'd4: ah_next = byte_w;
                        8'd6: waddr_next = {ah_reg, byte_w};
                        default: begin
                            // record type byte: length check comes first
                            if ({2'b00, len_reg} < need_w) begin
                                stat_next  = ST_SHORT;
                                state_next = S_FIN;
                            end else if (byte_w == 8'h00) begin
                                left_next = n_reg;
                            end else if (byte_w == 8'h01) begin
                                endseen_next = 1'b1;
                                left_next    = '0;
                                pos_next     = 8'(9'd9 + {n_reg, 1'b0});
                            end else begin
                                stat_next  = ST_TYPE;
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end else if (left_reg != '0) begin
                    img_we     = 1'b1;
                    tags_next[waddr_reg[IMG_AW-1 -: ROW_AW]] = 1'b1;
                    waddr_next = waddr_reg + 1'b1;
                    sum_next   = sum_reg + byte_w;
                    left_next  = left_reg - 1'b1;
                end else begin
                    stat_next  = (8'(sum_reg + byte_w) == 8'h00) ? ST_OK : ST_CSUM;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                count_next    = '0;
                zseen_next    = 1'b0;
                res_data_next = 8'h00;
                res_tag_next  = 1'b0;
                if (eof_reg) begin
                    res_kind_next = KIND_FILE;
                    if (stat_reg != ST_OK) begin
                        res_stat_next = stat_reg;
                    end else begin
                        res_stat_next = endseen_reg ? ST_OK : ST_NO_END;
                    end
                    held_next    = ST_OK;
                    endseen_next = 1'b0;
                end else begin
                    res_kind_next = KIND_LINE;
                    res_stat_next = stat_reg;
                    held_next     = stat_reg;
                end
                state_next = S_OUT;
            end
            S_RDIMG: begin
                res_kind_next = KIND_READ;
                res_stat_next = ST_OK;
                res_data_next = img_q_reg;
                res_tag_next  = tags_reg[rrow_reg];
                state_next    = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_stat_next  = res_stat_reg;
                    m_data_next  = res_data_reg;
                    m_tag_next   = res_tag_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/hrl_checker.sv -----
module hrl_checker
    import hrl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_op,
    input logic [7:0]        s_ch,
    input logic [IMG_AW-1:0] s_read_address,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_kind,
    input logic [2:0]        m_status,
    input logic [7:0]        m_read_data,
    input logic              m_row_tag
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_status)
            && $stable(m_read_data) && $stable(m_row_tag))
        else $error("result changed while stalled");

    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READ |-> m_status == ST_OK)
        else $error("read result carries a status");

    a_status_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_READ |-> m_read_data == 8'h00 && !m_row_tag)
        else $error("status result carries read data");

    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready during image clear");

    // a missing end record is only reported at end of file
    a_line_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_LINE |-> m_status != ST_NO_END)
        else $error("line status reports missing end record");

endmodule

bind hex_record_loader_unit hrl_checker u_hrl_checker (.*);

// ----- sim/hex_record_loader_unit_tb.sv -----
module hex_record_loader_unit_tb;
    import hrl_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [15:0] addr;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [7:0]  data;
        logic        tag;
    } rsp_t;

    // ways to break a record
    localparam int BRK_NONE  = 0;
    localparam int BRK_CSUM  = 1;
    localparam int BRK_HEX   = 2;
    localparam int BRK_COLON = 3;
    localparam int BRK_SHORT = 4;
    localparam int BRK_TYPE  = 5;
    localparam int BRK_NUL   = 6;
    localparam int BRK_LAST  = 6;

    localparam int ITEM_GOAL = 1800;
    localparam int HOLD_AT   = 67000;
    localparam int HOLD_LEN  = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_NONE;
    logic [7:0]  s_ch = 8'h00;
    logic [15:0] s_read_address = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [2:0]  m_status;
    logic [7:0]  m_read_data;
    logic        m_row_tag;

    hex_record_loader_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_ch           (s_ch),
        .s_read_address (s_read_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_status       (m_status),
        .m_read_data    (m_read_data),
        .m_row_tag      (m_row_tag)
    );

    req_t    feed_q[$];
    rsp_t    result_q[$];
    bit      feed_done = 1'b0;
    int      mismatches = 0;
    longint  cycle_cnt = 0;

    // shadow loader state
    bit [7:0] image_mem [65536];
    bit       row_seen [ROW_CNT];
    logic [7:0] line_mem [256];
    int       line_len = 0;
    bit       end_seen = 1'b0;
    status_t  first_err = ST_OK;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int hex_digit(int pos);
        logic [7:0] c;
        if (pos >= 256) return 16;
        c = line_mem[pos];
        if (c >= "0" && c <= "9") return c - "0";
        c = c & CASE_MASK;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic int hex_byte(int pos);
        int hi;
        int lo;
        hi = hex_digit(pos);
        lo = hex_digit(pos + 1);
        if (hi > 15 || lo > 15) return 256;
        return hi * 16 + lo;
    endfunction

    function automatic status_t parse_line();
        int len;
        int n;
        int ah;
        int al;
        int rtype;
        int sum;
        int b;
        int base;
        logic [15:0] idx;
        len = 0;
        while (len < line_len && len < 256 && line_mem[len] != CHAR_NUL) len++;
        if (len < 11) return ST_SHORT;
        if (line_mem[0] != COLON) return ST_COLON;
        n = hex_byte(1);
        if (n > 255) return ST_HEX;
        ah = hex_byte(3);
        if (ah > 255) return ST_HEX;
        al = hex_byte(5);
        if (al > 255) return ST_HEX;
        rtype = hex_byte(7);
        if (rtype > 255) return ST_HEX;
        sum = n + ah + al + rtype;
        base = ah * 256 + al;
        if (len < 11 + 2 * n) return ST_SHORT;
        if (rtype == 0) begin
            for (int i = 0; i < n; i++) begin
                b = hex_byte(9 + 2 * i);
                if (b > 255) return ST_HEX;
                sum += b;
                idx = 16'(base + i);
                image_mem[idx] = 8'(b);
                row_seen[idx[15:8]] = 1'b1;
            end
        end else if (rtype == 1) begin
            end_seen = 1'b1;
        end else begin
            return ST_TYPE;
        end
        b = hex_byte(9 + 2 * n);
        if (b > 255) return ST_HEX;
        if (((sum + b) & 255) != 0) return ST_CSUM;
        return ST_OK;
    endfunction

    function automatic status_t close_line();
        status_t s;
        if (first_err != ST_OK) begin
            s = first_err;
        end else begin
            s = parse_line();
            first_err = s;
        end
        line_len = 0;
        return s;
    endfunction

    function automatic void predict_loader(req_t r);
        status_t s;
        case (r.op)
            OP_CHAR: begin
                if (line_len >= 255) line_len = 0;
                line_mem[line_len] = r.ch;
                line_len++;
                if (r.ch == NEWLINE || line_len >= 255) begin
                    s = close_line();
                    result_q.push_back('{KIND_LINE, s, 8'h00, 1'b0});
                end
            end
            OP_EOF: begin
                if (line_len > 0) void'(close_line());
                if (first_err != ST_OK) s = first_err;
                else s = end_seen ? ST_OK : ST_NO_END;
                first_err = ST_OK;
                end_seen = 1'b0;
                line_len = 0;
                result_q.push_back('{KIND_FILE, s, 8'h00, 1'b0});
            end
            OP_READ: begin
                result_q.push_back('{KIND_READ, ST_OK, image_mem[r.addr],
                                     row_seen[r.addr[15:8]]});
            end
            default: ;
        endcase
    endfunction

    // stimulus helpers
    function automatic void add_char(logic [7:0] c);
        feed_q.push_back('{OP_CHAR, c, 16'($urandom)});
    endfunction

    function automatic void add_eof();
        feed_q.push_back('{OP_EOF, 8'($urandom), 16'($urandom)});
    endfunction

    function automatic void add_read(logic [15:0] a);
        feed_q.push_back('{OP_READ, 8'($urandom), a});
    endfunction

    function automatic logic [7:0] digit_char(int v);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(0, 1)) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0: c = "G";
            1: c = "g";
            2: c = "/";
            3: c = 8'h80 | 8'($urandom);
            default: c = ":";
        endcase
        return c;
    endfunction

    function automatic void add_record(int rtype, int n, logic [15:0] a, int brk);
        logic [7:0] bytes[$];
        logic [7:0] text[$];
        int sum;
        int pos;
        bytes.push_back(8'(n));
        bytes.push_back(a[15:8]);
        bytes.push_back(a[7:0]);
        bytes.push_back(8'(rtype));
        for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
        sum = 0;
        foreach (bytes[i]) sum += bytes[i];
        bytes.push_back(8'(-sum));
        if (brk == BRK_CSUM) bytes[bytes.size() - 1] ^= 8'($urandom_range(1, 255));
        text.push_back(COLON);
        foreach (bytes[i]) begin
            text.push_back(digit_char(bytes[i][7:4]));
            text.push_back(digit_char(bytes[i][3:0]));
        end
        case (brk)
            BRK_HEX: text[$urandom_range(1, text.size() - 1)] = junk_char();
            BRK_COLON: text[0] = 8'($urandom_range(1, 255)) == COLON ? "=" :
                                 8'($urandom_range(1, 255));
            BRK_SHORT: begin
                pos = $urandom_range(1, text.size() - 1);
                while (text.size() > pos) void'(text.pop_back());
            end
            BRK_NUL: text[$urandom_range(0, text.size() - 1)] = CHAR_NUL;
            default: ;
        endcase
        foreach (text[i]) add_char(text[i]);
        add_char(NEWLINE);
    endfunction

    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 3) != 0) return {8'h12 + 8'($urandom_range(0, 1)), 8'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic void add_file();
        int lines;
        int brk;
        int brk_line;
        lines = $urandom_range(1, 6);
        brk_line = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lines) : -1;
        for (int l = 0; l <= lines; l++) begin
            brk = (l == brk_line) ? $urandom_range(1, BRK_LAST) : BRK_NONE;
            if (l == lines) begin
                if ($urandom_range(0, 7) != 0) add_record(1, 0, 16'h0000, brk);
            end else if (brk == BRK_TYPE) begin
                add_record($urandom_range(2, 255), $urandom_range(0, 8), pick_addr(), BRK_NONE);
            end else begin
                add_record(0, ($urandom_range(0, 15) == 0) ? $urandom_range(17, 120)
                                                           : $urandom_range(0, 16),
                           pick_addr(), brk);
            end
            if ($urandom_range(0, 3) == 0) add_read(pick_addr());
        end
        add_eof();
    endfunction

    initial begin
        // directed: wrapped data record, random-case digits, end record, reads
        add_record(0, 3, 16'hffff, BRK_NONE);
        add_record(1, 0, 16'h0000, BRK_NONE);
        add_eof();
        add_read(16'hffff);
        add_read(16'h0001);
        add_read(16'h8000);
        feed_q.push_back('{OP_NONE, 8'hff, 16'hffff});
        // file without end record, then one with a bad type
        add_record(0, 0, 16'h0000, BRK_NONE);
        add_eof();
        add_record(7, 0, 16'h0000, BRK_NONE);
        add_eof();
        // pending characters with no newline at end of file
        add_char(COLON);
        add_char("0");
        add_eof();
        // full chunk with no newline, then end of file
        for (int i = 0; i < 300; i++) add_char(8'($urandom_range(11, 255)));
        add_eof();
        for (int b = BRK_CSUM; b <= BRK_LAST; b++) begin
            if (b == BRK_TYPE) add_record(2, 1, 16'h1200, BRK_NONE);
            else add_record(0, 2, 16'h1200, b);
            add_eof();
        end
        while (feed_q.size() < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: add_read(16'($urandom));
                1: begin
                    repeat ($urandom_range(1, 30)) add_char(8'($urandom));
                    add_eof();
                end
                2: feed_q.push_back('{OP_NONE, 8'($urandom), 16'($urandom)});
                default: add_file();
            endcase
        end
        for (int i = 0; i < 40; i++) add_read(pick_addr());
        feed_done = 1'b1;
    end

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_loader('{op_t'(s_op), s_ch, s_read_address});
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (feed_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    {s_op, s_ch, s_read_address} <= feed_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // long receiver hold-off, counted here
    bit hold_off = 1'b0;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        hold_off  <= (cycle_cnt >= HOLD_AT && cycle_cnt < HOLD_AT + HOLD_LEN);
    end

    // receiver stall pattern: always ready, light stalls, or heavy stalls
    int rx_mode = 0;
    int rx_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(50, 600);
            end else begin
                rx_left <= rx_left - 1;
            end
            if (hold_off) m_ready <= 1'b0;
            else if (rx_mode == 0) m_ready <= 1'b1;
            else if (rx_mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d status %0d data %02h tag %0b",
                             m_kind, m_status, m_read_data, m_row_tag);
            end else begin
                want = result_q.pop_front();
                if (m_kind !== want.kind || m_status !== want.status ||
                    m_read_data !== want.data || m_row_tag !== want.tag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: kind %0d/%0d status %0d/%0d data %02h/%02h tag %0b/%0b",
                                 want.kind, m_kind, want.status, m_status,
                                 want.data, m_read_data, want.tag, m_row_tag);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!feed_done || feed_q.size() != 0 || s_valid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
